// File: hdl/i2cms_pkg.sv
// Shared types, operation codes and phase constants for the I2C master byte sequencer.
package i2cms_pkg;

   localparam int unsigned BITS_PER_BYTE = 8;
   localparam logic [7:0] MSB_MASK = 8'h80;
   localparam logic [15:0] PHASE_TICKS_RESET = 16'd10;

   // Phase numbers at which the write and read sequences change character.
   localparam logic [5:0] WR_LAST_BIT_PHASE = 6'(2 * BITS_PER_BYTE);
   localparam logic [5:0] WR_ACK_HIGH_PHASE = 6'(2 * BITS_PER_BYTE + 1);
   localparam logic [5:0] WR_ACK_SMP_PHASE = 6'(2 * BITS_PER_BYTE + 2);
   localparam logic [5:0] RD_LAST_BIT_PHASE = 6'(1 + 3 * BITS_PER_BYTE);
   localparam logic [5:0] RD_ACK_HIGH_PHASE = 6'(2 + 3 * BITS_PER_BYTE);
   localparam logic [5:0] RD_ACK_LOW_PHASE = 6'(3 + 3 * BITS_PER_BYTE);
   localparam logic [3:0] BIT_COUNT_FULL = 4'(BITS_PER_BYTE);

   // The tick code doubles as the idle value of the current command.
   typedef enum logic [2:0] {
      OP_TICK  = 3'd0,
      OP_START = 3'd1,
      OP_WRITE = 3'd2,
      OP_READ  = 3'd3,
      OP_STOP  = 3'd4
   } op_type;

   // Position within the low, high and sample steps of one read bit.
   typedef enum logic [1:0] {
      RD_STEP_LOW    = 2'd0,
      RD_STEP_HIGH   = 2'd1,
      RD_STEP_SAMPLE = 2'd2
   } rd_step_type;

   typedef struct packed {
      logic [2:0] op;
      logic [7:0] write_byte;
      logic       send_nack;
      logic       sda_in;
   } req_type;

   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_byte;
      logic       slave_nack;
      logic       rejected;
   } rsp_type;

endpackage

// File: hdl/i2cms_ifs.sv
// Valid/ready channel interfaces for the request and response transfers.
interface i2cms_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] op;
   logic [7:0] write_byte;
   logic       send_nack;
   logic       sda_in;

   modport source (output valid, output op, output write_byte, output send_nack,
                   output sda_in, input ready);
   modport sink (input valid, input op, input write_byte, input send_nack,
                 input sda_in, output ready);
endinterface

interface i2cms_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_out;
   logic       sda_out;
   logic       busy_res;
   logic       done_res;
   logic [7:0] read_byte;
   logic       slave_nack;
   logic       rejected;

   modport source (output valid, output scl_out, output sda_out, output busy_res,
                   output done_res, output read_byte, output slave_nack,
                   output rejected, input ready);
   modport sink (input valid, input scl_out, input sda_out, input busy_res,
                 input done_res, input read_byte, input slave_nack,
                 input rejected, output ready);
endinterface

// File: hdl/i2cms_engine.sv
// Sequencer state and the single-step action logic for each accepted item.
module i2cms_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  i2cms_pkg::req_type   req,
   input  logic [15:0]          phase_ticks,
   output i2cms_pkg::rsp_type   rsp
);

   i2cms_pkg::op_type      cmd_ff, cmd_in;
   i2cms_pkg::rd_step_type rd_step_ff, rd_step_in;
   logic [5:0]  phase_ff, phase_in;
   logic [3:0]  bit_cnt_ff, bit_cnt_in;
   logic [7:0]  shift_ff, shift_in;
   logic [15:0] tick_ff, tick_in;
   logic        ack_choice_ff, ack_choice_in;
   logic        scl_ff, scl_in;
   logic        sda_ff, sda_in;
   logic        ack_smp_ff, ack_smp_in;

   logic              act;
   logic              fin;
   logic              rej;
   logic              act_sda;
   logic [15:0]       limit;
   i2cms_pkg::op_type act_cmd;

   always_comb begin
      cmd_in        = cmd_ff;
      rd_step_in    = rd_step_ff;
      phase_in      = phase_ff;
      bit_cnt_in    = bit_cnt_ff;
      shift_in      = shift_ff;
      tick_in       = tick_ff;
      ack_choice_in = ack_choice_ff;
      scl_in        = scl_ff;
      sda_in        = sda_ff;
      ack_smp_in    = ack_smp_ff;
      act           = 1'b0;
      fin           = 1'b0;
      rej           = 1'b0;
      act_sda       = 1'b0;
      act_cmd       = cmd_ff;
      limit         = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;

      // Decode the item and decide whether an action point falls on it.
      case (req.op)
         i2cms_pkg::OP_TICK: begin
            if (cmd_ff != i2cms_pkg::OP_TICK) begin
               tick_in = tick_ff + 16'd1;
               if (tick_in >= limit) begin
                  tick_in  = 16'd0;
                  phase_in = phase_ff + 6'd1;
                  act      = 1'b1;
                  act_sda  = req.sda_in;
               end
            end
         end
         i2cms_pkg::OP_START, i2cms_pkg::OP_WRITE, i2cms_pkg::OP_READ,
         i2cms_pkg::OP_STOP: begin
            if (cmd_ff != i2cms_pkg::OP_TICK) begin
               rej = 1'b1;
            end else begin
               cmd_in     = i2cms_pkg::op_type'(req.op);
               act_cmd    = cmd_in;
               phase_in   = 6'd0;
               tick_in    = 16'd0;
               bit_cnt_in = 4'd0;
               rd_step_in = i2cms_pkg::RD_STEP_LOW;
               if (cmd_in == i2cms_pkg::OP_WRITE) begin
                  shift_in   = req.write_byte;
                  ack_smp_in = 1'b0;
               end
               if (cmd_in == i2cms_pkg::OP_READ) begin
                  shift_in      = 8'd0;
                  ack_choice_in = req.send_nack;
               end
               act = 1'b1;
            end
         end
         default: begin
         end
      endcase

      // Carry out the action point of the current phase.
      if (act) begin
         case (act_cmd)
            i2cms_pkg::OP_START: begin
               if (phase_in == 6'd0) begin
                  scl_in = 1'b1;
                  sda_in = 1'b1;
               end else if (phase_in == 6'd1) begin
                  sda_in = 1'b0;
               end else begin
                  scl_in = 1'b0;
                  fin    = 1'b1;
               end
            end
            i2cms_pkg::OP_STOP: begin
               if (phase_in == 6'd0) begin
                  sda_in = 1'b0;
                  scl_in = 1'b0;
               end else if (phase_in == 6'd1) begin
                  scl_in = 1'b1;
               end else begin
                  sda_in = 1'b1;
                  fin    = 1'b1;
               end
            end
            i2cms_pkg::OP_WRITE: begin
               if (phase_in <= i2cms_pkg::WR_LAST_BIT_PHASE) begin
                  if (phase_in[0]) begin
                     scl_in = 1'b1;
                  end else begin
                     if (phase_in != 6'd0) begin
                        scl_in = 1'b0;
                     end
                     // After the eighth bit SDA is released for the acknowledge.
                     if (bit_cnt_in < i2cms_pkg::BIT_COUNT_FULL) begin
                        sda_in     = |(shift_in & i2cms_pkg::MSB_MASK);
                        shift_in   = {shift_in[6:0], 1'b0};
                        bit_cnt_in = bit_cnt_in + 4'd1;
                     end else begin
                        sda_in = 1'b1;
                     end
                  end
               end else if (phase_in == i2cms_pkg::WR_ACK_HIGH_PHASE) begin
                  scl_in = 1'b1;
               end else if (phase_in == i2cms_pkg::WR_ACK_SMP_PHASE) begin
                  ack_smp_in = act_sda;
                  scl_in     = 1'b0;
               end else begin
                  fin = 1'b1;
               end
            end
            i2cms_pkg::OP_READ: begin
               if (phase_in == 6'd0) begin
                  scl_in = 1'b0;
               end else if (phase_in == 6'd1) begin
                  sda_in = 1'b1;
               end else if (phase_in <= i2cms_pkg::RD_LAST_BIT_PHASE) begin
                  case (rd_step_ff)
                     i2cms_pkg::RD_STEP_LOW: begin
                        scl_in     = 1'b0;
                        rd_step_in = i2cms_pkg::RD_STEP_HIGH;
                     end
                     i2cms_pkg::RD_STEP_HIGH: begin
                        scl_in     = 1'b1;
                        rd_step_in = i2cms_pkg::RD_STEP_SAMPLE;
                     end
                     default: begin
                        shift_in   = {shift_in[6:0], act_sda};
                        bit_cnt_in = bit_cnt_in + 4'd1;
                        rd_step_in = i2cms_pkg::RD_STEP_LOW;
                        if (phase_in == i2cms_pkg::RD_LAST_BIT_PHASE) begin
                           scl_in = 1'b0;
                        end
                     end
                  endcase
               end else if (phase_in == i2cms_pkg::RD_ACK_HIGH_PHASE) begin
                  sda_in = ack_choice_in;
                  scl_in = 1'b1;
               end else if (phase_in == i2cms_pkg::RD_ACK_LOW_PHASE) begin
                  scl_in = 1'b0;
               end else begin
                  fin = 1'b1;
               end
            end
            default: begin
               fin = 1'b1;
            end
         endcase
      end

      if (fin) begin
         cmd_in   = i2cms_pkg::OP_TICK;
         phase_in = 6'd0;
         tick_in  = 16'd0;
      end

      rsp.scl_out    = scl_in;
      rsp.sda_out    = sda_in;
      rsp.busy_res   = (cmd_in != i2cms_pkg::OP_TICK);
      rsp.done_res   = fin;
      rsp.read_byte  = (fin && act_cmd == i2cms_pkg::OP_READ) ? shift_in : 8'd0;
      rsp.slave_nack = fin && (act_cmd == i2cms_pkg::OP_WRITE) && ack_smp_in;
      rsp.rejected   = rej;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff        <= i2cms_pkg::OP_TICK;
         rd_step_ff    <= i2cms_pkg::RD_STEP_LOW;
         phase_ff      <= 6'd0;
         bit_cnt_ff    <= 4'd0;
         shift_ff      <= 8'd0;
         tick_ff       <= 16'd0;
         ack_choice_ff <= 1'b1;
         scl_ff        <= 1'b1;
         sda_ff        <= 1'b1;
         ack_smp_ff    <= 1'b0;
      end else if (accept) begin
         cmd_ff        <= cmd_in;
         rd_step_ff    <= rd_step_in;
         phase_ff      <= phase_in;
         bit_cnt_ff    <= bit_cnt_in;
         shift_ff      <= shift_in;
         tick_ff       <= tick_in;
         ack_choice_ff <= ack_choice_in;
         scl_ff        <= scl_in;
         sda_ff        <= sda_in;
         ack_smp_ff    <= ack_smp_in;
      end
   end

endmodule

// File: hdl/i2c_master_byte_sequencer_top.sv
// Top level: request/response handshakes, phase length register and result buffer.
// Each accepted item updates the sequencer state and its result is registered in
// the result buffer before it is offered on the response channel.
// One item is accepted per cycle; a two-entry result buffer keeps the input open
// while one result waits, and the input stalls only when both entries are full.
// Synchronous reset: idle, SCL and SDA released, phase_ticks back to 10.
module i2c_master_byte_sequencer_top (
   input  logic          clock,
   input  logic          reset,
   i2cms_req_if.sink     req_chan,
   i2cms_rsp_if.source   rsp_chan,
   input  logic          csr_write_en,
   input  logic [15:0]   csr_write_data
);

   logic [15:0]        phase_ticks_ff;
   logic               accept;
   i2cms_pkg::req_type req;
   i2cms_pkg::rsp_type result;

   logic               main_valid_ff, main_valid_in;
   logic               skid_valid_ff, skid_valid_in;
   i2cms_pkg::rsp_type main_ff, main_in;
   i2cms_pkg::rsp_type skid_ff, skid_in;
   logic               pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ticks_ff <= i2cms_pkg::PHASE_TICKS_RESET;
      end else if (csr_write_en) begin
         phase_ticks_ff <= csr_write_data;
      end
   end

   assign req_chan.ready = !skid_valid_ff;
   assign accept = req_chan.valid && req_chan.ready;

   assign req.op         = req_chan.op;
   assign req.write_byte = req_chan.write_byte;
   assign req.send_nack  = req_chan.send_nack;
   assign req.sda_in     = req_chan.sda_in;

   i2cms_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req         (req),
      .phase_ticks (phase_ticks_ff),
      .rsp         (result)
   );

   // The skid entry fills only when the head entry is held by a stalled transfer.
   assign pop = main_valid_ff && rsp_chan.ready;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (pop || !main_valid_ff) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
            if (accept) begin
               skid_in       = result;
               skid_valid_in = 1'b1;
            end
         end else if (accept) begin
            main_in       = result;
            main_valid_in = 1'b1;
         end else begin
            main_valid_in = 1'b0;
         end
      end else if (accept) begin
         skid_in       = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp_chan.valid      = main_valid_ff;
   assign rsp_chan.scl_out    = main_ff.scl_out;
   assign rsp_chan.sda_out    = main_ff.sda_out;
   assign rsp_chan.busy_res   = main_ff.busy_res;
   assign rsp_chan.done_res   = main_ff.done_res;
   assign rsp_chan.read_byte  = main_ff.read_byte;
   assign rsp_chan.slave_nack = main_ff.slave_nack;
   assign rsp_chan.rejected   = main_ff.rejected;

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the I2C master byte sequencer: random traffic against a line predictor.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NBITS = 8;
   localparam int WR_STEPS = 2 * NBITS + 3;
   localparam int RD_STEPS = 3 * NBITS + 4;
   localparam int CTRL_STEPS = 2;
   localparam logic [2:0] OP_SPARE_LO = 3'd5;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;
   localparam int unsigned CYCLE_LIMIT = 4000000;
   localparam int unsigned HOLD_AT = 200;
   localparam int unsigned HOLD_CYCLES = 400;
   localparam int unsigned QUIET_CYCLES = 4;
   localparam int unsigned LONG_PHASE_TICKS = 8;

   typedef enum logic [1:0] {SDA_LOW, SDA_HIGH, SDA_RANDOM} sda_drive_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_en;
   logic [15:0] csr_write_data;

   i2cms_req_if req_bus ();
   i2cms_rsp_if rsp_bus ();

   i2c_master_byte_sequencer_top u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_bus),
      .rsp_chan       (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Predicted bus state, mirroring the sequencer after every accepted item.
   logic [15:0] cfg_phase_ticks = i2cms_pkg::PHASE_TICKS_RESET;
   logic [2:0] line_cmd = i2cms_pkg::OP_TICK;
   logic [5:0] line_phase = '0;
   logic [3:0] line_bits = '0;
   logic [7:0] line_shift = '0;
   logic [15:0] line_ticks = '0;
   logic line_ack_choice = 1'b1;
   logic line_scl = 1'b1;
   logic line_sda = 1'b1;
   logic line_ack_seen = 1'b0;

   i2cms_pkg::req_type cmd_queue[$];
   i2cms_pkg::rsp_type bus_result_q[$];
   int unsigned taken_count = 0;
   int unsigned checked_count = 0;
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   int unsigned burst_left = 1;
   int unsigned gap_left = 0;
   int unsigned stall_left = 0;
   logic [31:0] stall_bits = '1;
   int unsigned hold_left = 0;
   logic hold_fired = 1'b0;

   function automatic void shift_bit_out();
      line_sda = line_shift[7];
      line_shift = {line_shift[6:0], 1'b0};
      line_bits = line_bits + 4'd1;
   endfunction

   // Carries out the current action point; returns 1 when the command has finished.
   function automatic logic line_action(input logic smp);
      int p;
      logic fin;
      p = line_phase;
      fin = 1'b0;
      case (line_cmd)
         i2cms_pkg::OP_START: begin
            if (p == 0) begin
               line_scl = 1'b1;
               line_sda = 1'b1;
            end else if (p == 1) begin
               line_sda = 1'b0;
            end else begin
               line_scl = 1'b0;
               fin = 1'b1;
            end
         end
         i2cms_pkg::OP_STOP: begin
            if (p == 0) begin
               line_sda = 1'b0;
               line_scl = 1'b0;
            end else if (p == 1) begin
               line_scl = 1'b1;
            end else begin
               line_sda = 1'b1;
               fin = 1'b1;
            end
         end
         i2cms_pkg::OP_WRITE: begin
            if (p == 0) begin
               shift_bit_out();
            end else if (p <= 2 * NBITS) begin
               if (p % 2 == 1) begin
                  line_scl = 1'b1;
               end else begin
                  line_scl = 1'b0;
                  if (line_bits < NBITS) shift_bit_out();
                  else line_sda = 1'b1;
               end
            end else if (p == 2 * NBITS + 1) begin
               line_scl = 1'b1;
            end else if (p == 2 * NBITS + 2) begin
               line_ack_seen = smp;
               line_scl = 1'b0;
            end else begin
               fin = 1'b1;
            end
         end
         i2cms_pkg::OP_READ: begin
            if (p == 0) begin
               line_scl = 1'b0;
            end else if (p == 1) begin
               line_sda = 1'b1;
            end else if (p <= 1 + 3 * NBITS) begin
               case ((p - 2) % 3)
                  0: line_scl = 1'b0;
                  1: line_scl = 1'b1;
                  default: begin
                     line_shift = {line_shift[6:0], smp};
                     line_bits = line_bits + 4'd1;
                     if (p == 1 + 3 * NBITS) line_scl = 1'b0;
                  end
               endcase
            end else if (p == 2 + 3 * NBITS) begin
               line_sda = line_ack_choice;
               line_scl = 1'b1;
            end else if (p == 3 + 3 * NBITS) begin
               line_scl = 1'b0;
            end else begin
               fin = 1'b1;
            end
         end
         default: fin = 1'b1;
      endcase
      return fin;
   endfunction

   function automatic i2cms_pkg::rsp_type line_step(input i2cms_pkg::req_type r);
      i2cms_pkg::rsp_type o;
      logic fin;
      logic [2:0] fin_cmd;
      logic [15:0] lim;
      o = '0;
      fin = 1'b0;
      fin_cmd = i2cms_pkg::OP_TICK;
      lim = (cfg_phase_ticks == 16'd0) ? 16'd1 : cfg_phase_ticks;
      if (r.op == i2cms_pkg::OP_TICK) begin
         if (line_cmd != i2cms_pkg::OP_TICK) begin
            line_ticks = line_ticks + 16'd1;
            if (line_ticks >= lim) begin
               line_ticks = '0;
               line_phase = line_phase + 6'd1;
               fin_cmd = line_cmd;
               fin = line_action(r.sda_in);
            end
         end
      end else if (r.op <= i2cms_pkg::OP_STOP) begin
         if (line_cmd != i2cms_pkg::OP_TICK) begin
            o.rejected = 1'b1;
         end else begin
            line_cmd = r.op;
            line_phase = '0;
            line_ticks = '0;
            line_bits = '0;
            if (r.op == i2cms_pkg::OP_WRITE) begin
               line_shift = r.write_byte;
               line_ack_seen = 1'b0;
            end
            if (r.op == i2cms_pkg::OP_READ) begin
               line_shift = '0;
               line_ack_choice = r.send_nack;
            end
            fin_cmd = r.op;
            fin = line_action(1'b0);
         end
      end
      if (fin) begin
         o.done_res = 1'b1;
         line_cmd = i2cms_pkg::OP_TICK;
         line_phase = '0;
         line_ticks = '0;
      end
      o.scl_out = line_scl;
      o.sda_out = line_sda;
      o.busy_res = (line_cmd != i2cms_pkg::OP_TICK);
      if (fin && fin_cmd == i2cms_pkg::OP_READ) o.read_byte = line_shift;
      if (fin && fin_cmd == i2cms_pkg::OP_WRITE) o.slave_nack = line_ack_seen;
      return o;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      error_count++;
      if (error_count <= 100)
         $display("mismatch: %s at result %0d, got %0h, expected %0h",
                  what, checked_count, got, want);
   endtask

   task automatic push_item(input logic [2:0] op, input logic [7:0] wb, input logic nack,
                            input logic sda);
      i2cms_pkg::req_type r;
      r.op = op;
      r.write_byte = wb;
      r.send_nack = nack;
      r.sda_in = sda;
      cmd_queue.push_back(r);
   endtask

   // Queues a command and the ticks it needs to finish; noise_pm is the chance, per
   // thousand ticks, of a stray command or spare op slipping in mid-sequence.
   task automatic push_cmd(input logic [2:0] op, input logic [7:0] wb, input logic nack,
                           input sda_drive_type mode, input int unsigned noise_pm);
      int unsigned per;
      int unsigned n;
      int unsigned i;
      logic sda;
      per = (cfg_phase_ticks == 16'd0) ? 1 : cfg_phase_ticks;
      case (op)
         i2cms_pkg::OP_WRITE: n = WR_STEPS * per;
         i2cms_pkg::OP_READ: n = RD_STEPS * per;
         default: n = CTRL_STEPS * per;
      endcase
      push_item(op, wb, nack, 1'($urandom));
      for (i = 0; i < n; i++) begin
         if ($urandom_range(0, 999) < noise_pm)
            push_item(3'($urandom_range(i2cms_pkg::OP_START, OP_SPARE_HI)), 8'($urandom),
                      1'($urandom), 1'($urandom));
         if (mode == SDA_RANDOM) sda = 1'($urandom);
         else sda = (mode == SDA_HIGH);
         push_item(i2cms_pkg::OP_TICK, 8'($urandom), 1'($urandom), sda);
      end
   endtask

   // A mostly well-formed bus transaction with random content, sometimes without its stop.
   task automatic queue_transaction(input int unsigned max_bytes);
      int unsigned nbytes;
      int unsigned i;
      logic [2:0] op;
      push_cmd(i2cms_pkg::OP_START, 8'($urandom), 1'($urandom), SDA_RANDOM, 30);
      nbytes = $urandom_range(1, max_bytes);
      for (i = 0; i < nbytes; i++) begin
         repeat ($urandom_range(0, 1)) begin
            op = ($urandom_range(0, 2) == 0) ? i2cms_pkg::OP_TICK
                 : 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
            push_item(op, 8'($urandom), 1'($urandom), 1'($urandom));
         end
         if ($urandom_range(0, 5) == 0)
            push_cmd(i2cms_pkg::OP_START, 8'($urandom), 1'($urandom), SDA_RANDOM, 30);
         if (i == 0 || $urandom_range(0, 1) == 0)
            push_cmd(i2cms_pkg::OP_WRITE, 8'($urandom), 1'($urandom), SDA_RANDOM, 30);
         else
            push_cmd(i2cms_pkg::OP_READ, 8'($urandom), 1'($urandom), SDA_RANDOM, 30);
      end
      if ($urandom_range(0, 7) != 0)
         push_cmd(i2cms_pkg::OP_STOP, 8'($urandom), 1'($urandom), SDA_RANDOM, 30);
   endtask

   // Waits until every queued item has been sent and every result has come back.
   task automatic wait_quiet();
      while (cmd_queue.size() != 0 || bus_result_q.size() != 0 || req_bus.valid)
         @(negedge clock);
      repeat (QUIET_CYCLES) @(negedge clock);
   endtask

   task automatic set_phase_ticks(input logic [15:0] v);
      wait_quiet();
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_en <= 1'b0;
      cfg_phase_ticks = v;
      @(negedge clock);
   endtask

   // Sender: offers queued items in bursts separated by random gaps.
   always @(posedge clock) begin : feed
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            bus_result_q.push_back(line_step(cmd_queue[0]));
            void'(cmd_queue.pop_front());
            taken_count++;
         end
         if (req_bus.valid && !req_bus.ready) begin
            // The offered item stays on the bus until its transfer.
         end else if (gap_left != 0) begin
            gap_left--;
            req_bus.valid <= 1'b0;
         end else if (cmd_queue.size() != 0) begin
            req_bus.valid <= 1'b1;
            req_bus.op <= cmd_queue[0].op;
            req_bus.write_byte <= cmd_queue[0].write_byte;
            req_bus.send_nack <= cmd_queue[0].send_nack;
            req_bus.sda_in <= cmd_queue[0].sda_in;
            burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 20);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Receiver: checks each result transfer and stalls on a pattern of its own.
   always @(posedge clock) begin : watch
      i2cms_pkg::rsp_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (bus_result_q.size() == 0) begin
               report_mismatch("result with nothing expected", 0, 0);
            end else begin
               want = bus_result_q.pop_front();
               if (rsp_bus.scl_out !== want.scl_out)
                  report_mismatch("scl_out", rsp_bus.scl_out, want.scl_out);
               if (rsp_bus.sda_out !== want.sda_out)
                  report_mismatch("sda_out", rsp_bus.sda_out, want.sda_out);
               if (rsp_bus.busy_res !== want.busy_res)
                  report_mismatch("busy_res", rsp_bus.busy_res, want.busy_res);
               if (rsp_bus.done_res !== want.done_res)
                  report_mismatch("done_res", rsp_bus.done_res, want.done_res);
               if (rsp_bus.read_byte !== want.read_byte)
                  report_mismatch("read_byte", rsp_bus.read_byte, want.read_byte);
               if (rsp_bus.slave_nack !== want.slave_nack)
                  report_mismatch("slave_nack", rsp_bus.slave_nack, want.slave_nack);
               if (rsp_bus.rejected !== want.rejected)
                  report_mismatch("rejected", rsp_bus.rejected, want.rejected);
            end
            checked_count++;
         end
         if (stall_left == 0) begin
            case ($urandom_range(0, 3))
               0: stall_bits = '1;
               1: stall_bits = $urandom | $urandom;
               2: stall_bits = $urandom;
               default: stall_bits = $urandom | $urandom | $urandom;
            endcase
            stall_left = 32;
         end
         stall_left--;
         rsp_bus.ready <= stall_bits[0] && (hold_left == 0);
         stall_bits = stall_bits >> 1;
      end
   end

   // One long hold-off on the result side while the sender keeps going.
   always @(posedge clock) begin : long_hold
      if (reset) begin
         hold_left <= 0;
      end else if (!hold_fired && taken_count >= HOLD_AT) begin
         hold_left <= HOLD_CYCLES;
         hold_fired <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      req_bus.valid = 1'b0;
      req_bus.op = i2cms_pkg::OP_TICK;
      req_bus.write_byte = '0;
      req_bus.send_nack = 1'b0;
      req_bus.sda_in = 1'b0;
      rsp_bus.ready = 1'b0;
      csr_write_en = 1'b0;
      csr_write_data = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Default phase length: idle tick, spare op, start, a command while busy.
      push_item(i2cms_pkg::OP_TICK, 8'hFF, 1'b1, 1'b1);
      push_item(OP_SPARE_HI, 8'h00, 1'b0, 1'b0);
      push_item(i2cms_pkg::OP_START, 8'h00, 1'b0, 1'b1);
      push_item(i2cms_pkg::OP_WRITE, 8'hA5, 1'b1, 1'b0);
      repeat (CTRL_STEPS * i2cms_pkg::PHASE_TICKS_RESET)
         push_item(i2cms_pkg::OP_TICK, 8'($urandom), 1'($urandom), 1'($urandom));

      // Zero phase length behaves as one; byte extremes, ack and nack both ways.
      set_phase_ticks(16'd0);
      push_cmd(i2cms_pkg::OP_WRITE, 8'hFF, 1'b0, SDA_HIGH, 0);
      push_cmd(i2cms_pkg::OP_WRITE, 8'h00, 1'b1, SDA_LOW, 0);
      push_cmd(i2cms_pkg::OP_READ, 8'h00, 1'b1, SDA_HIGH, 0);
      push_cmd(i2cms_pkg::OP_READ, 8'hFF, 1'b0, SDA_LOW, 0);
      push_cmd(i2cms_pkg::OP_STOP, 8'($urandom), 1'($urandom), SDA_RANDOM, 0);

      set_phase_ticks(16'd1);
      repeat (2) queue_transaction(4);
      set_phase_ticks(16'd2);
      queue_transaction(2);
      set_phase_ticks(16'd3);
      queue_transaction(2);
      set_phase_ticks(16'($urandom_range(4, 7)));
      queue_transaction(1);

      // Longest phase: a start whose first phase never runs out, and a command while busy.
      set_phase_ticks(16'hFFFF);
      push_item(i2cms_pkg::OP_START, 8'($urandom), 1'($urandom), 1'($urandom));
      repeat (LONG_PHASE_TICKS)
         push_item(i2cms_pkg::OP_TICK, 8'($urandom), 1'($urandom), 1'($urandom));
      push_item(i2cms_pkg::OP_READ, 8'($urandom), 1'($urandom), 1'($urandom));
      repeat (LONG_PHASE_TICKS)
         push_item(i2cms_pkg::OP_TICK, 8'($urandom), 1'($urandom), 1'($urandom));

      wait_quiet();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// File: files.f
hdl/i2cms_pkg.sv
hdl/i2cms_ifs.sv
hdl/i2cms_engine.sv
hdl/i2c_master_byte_sequencer_top.sv
tb/tb_top.sv
